>>> src/filtered_group_by_aggregator_macros.svh
// assertion macros shared by the checker
// no dependencies
`ifndef FILTERED_GROUP_BY_AGGREGATOR_MACROS_SVH
`define FILTERED_GROUP_BY_AGGREGATOR_MACROS_SVH
// property a implies property b in the next cycle
`define FGA_ASSERT_NEXT(label, clk, rstn, a, b) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) \
        else $error("assertion failed");
// property a implies b in the same cycle
`define FGA_ASSERT_NOW(label, clk, rstn, a, b) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (b)) \
        else $error("assertion failed");
`endif

>>> src/fga_pkg.sv
// shared types, constants and codes of the filtered group-by aggregator
// no dependencies
`timescale 1ns / 1ps
package fga_pkg;
    localparam int KeyCodes   = 4096;
    localparam int GroupCodes = 32;
    localparam int AggGroups  = 4096;
    localparam int DictCodes  = 1024;
    localparam int Filters    = 4;

    localparam int KmapDepth = 4 * KeyCodes;
    localparam int CkDepth   = GroupCodes * GroupCodes * GroupCodes;
    localparam int DictDepth = 4 * DictCodes;
    localparam int KmapAw    = $clog2(KmapDepth);
    localparam int CkAw      = $clog2(CkDepth);
    localparam int DictAw    = $clog2(DictDepth);
    localparam int AggAw     = $clog2(AggGroups);
    localparam int GrpW      = $clog2(GroupCodes);
    localparam int KcW       = $clog2(KeyCodes);
    localparam int DcW       = $clog2(DictCodes);

    localparam int InW  = 112;
    localparam int OutW = 80;

    typedef enum logic [2:0] {
        OP_ROW = 3'd0, OP_LD_KMAP = 3'd1, OP_LD_CK = 3'd2,
        OP_LD_DICT = 3'd3, OP_READ = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        ST_ADDED = 3'd0, ST_FILTERED = 3'd1, ST_MISSING = 3'd2,
        ST_LOADED = 3'd3, ST_READ = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        CFG_MODE = 2'd0, CFG_MASK = 2'd1, CFG_DIMS = 2'd2
    } cfg_idx_t;

    localparam logic [1:0] MODE_COST = 2'd1;
    localparam logic [1:0] MODE_PROD = 2'd2;

    // back end sequencer states
    typedef enum logic [3:0] {
        B_CLEAR, B_IDLE, B_K0, B_K1, B_K2, B_KW, B_CK, B_CKW,
        B_SUM, B_SUMW, B_ACC, B_OUT
    } bstate_t;

    // classified command passed from front to back
    typedef struct packed {
        logic [2:0]  op;
        logic        pass;
        logic [1:0]  mode;
        logic [1:0]  dims;
        logic [11:0] kc0;
        logic [11:0] kc1;
        logic [11:0] kc2;
        logic [9:0]  va;
        logic [9:0]  vb;
        logic [1:0]  sel;
        logic [14:0] idx;
        logic [31:0] data;
    } cmd_t;

    localparam int CmdW = $bits(cmd_t);
endpackage

>>> src/fga_ram.sv
// generic single write, single read ram with registered read
// no dependencies
`timescale 1ns / 1ps
module fga_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> src/fga_front.sv
// front end: configuration registers, filter check and command queue
// depends on fga_pkg
`timescale 1ns / 1ps
module fga_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [fga_pkg::InW-1:0] s_tdata,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [1:0]           cfg_index,
    input  logic [31:0]          cfg_data,
    output logic                 q_valid,
    input  logic                 q_ready,
    output fga_pkg::cmd_t        q_cmd
);
    import fga_pkg::*;

    logic [1:0] mode_reg;
    logic [3:0] mask_reg;
    logic [1:0] dims_reg;
    cmd_t       buf_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic       wp_reg, rp_reg;
    cmd_t       cmd;
    logic [3:0] mask_eff;
    logic       push, pop;

    assign cfg_ready = 1'b1;
    assign mask_eff  = mask_reg & 4'((1 << Filters) - 1);

    always_comb begin
        cmd      = '0;
        cmd.op   = s_tdata[2:0];
        cmd.kc0  = s_tdata[18:7];
        cmd.kc1  = s_tdata[30:19];
        cmd.kc2  = s_tdata[42:31];
        cmd.va   = s_tdata[52:43];
        cmd.vb   = s_tdata[62:53];
        cmd.sel  = s_tdata[64:63];
        cmd.idx  = s_tdata[79:65];
        cmd.data = s_tdata[111:80];
        cmd.pass = ((s_tdata[6:3] & mask_eff) == mask_eff);
        cmd.mode = mode_reg;
        cmd.dims = dims_reg;
    end

    assign s_tready = (cnt_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign pop      = q_valid && q_ready;
    assign q_cmd    = buf_reg[rp_reg];
    assign cnt_next = cnt_reg + 2'(push) - 2'(pop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= '0;
            mask_reg <= '0;
            dims_reg <= '0;
            cnt_reg  <= '0;
            wp_reg   <= 1'b0;
            rp_reg   <= 1'b0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_MODE: mode_reg <= cfg_data[1:0];
                    CFG_MASK: mask_reg <= cfg_data[3:0];
                    CFG_DIMS: dims_reg <= cfg_data[1:0];
                    default:  ;
                endcase
            end
            cnt_reg <= cnt_next;
            if (push) wp_reg <= !wp_reg;
            if (pop)  rp_reg <= !rp_reg;
        end
        if (push) begin
            buf_reg[wp_reg] <= cmd;
        end
    end
endmodule

>>> src/fga_back.sv
// back end: table lookups, accumulation, loads and reads
// depends on fga_pkg and fga_ram
`timescale 1ns / 1ps
module fga_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            q_valid,
    output logic            q_ready,
    input  fga_pkg::cmd_t   q_cmd,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [fga_pkg::OutW-1:0] m_tdata
);
    import fga_pkg::*;

    bstate_t     st_reg, st_next;
    cmd_t        c_reg, c_next;
    logic [AggAw:0] clr_reg, clr_next;
    logic [1:0]  dim_reg, dim_next;
    logic [GrpW-1:0] g0_reg, g0_next, g1_reg, g1_next, g2_reg, g2_next;
    logic        miss_reg, miss_next;
    logic [AggAw-1:0] key_reg, key_next;
    logic [31:0] amt_reg, amt_next, va_reg, va_next;
    logic [2:0]  ost_reg, ost_next;
    logic [11:0] ogi_reg, ogi_next;
    logic [63:0] osum_reg, osum_next;

    logic km_we; logic [KmapAw-1:0] km_wa, km_ra; logic [5:0] km_wd, km_rd;
    logic ck_we; logic [CkAw-1:0] ck_wa, ck_ra; logic [11:0] ck_wd, ck_rd;
    logic dc_we; logic [DictAw-1:0] dc_wa, dc_ra; logic [31:0] dc_wd, dc_rd;
    logic sm_we; logic [AggAw-1:0] sm_wa, sm_ra; logic [63:0] sm_wd, sm_rd;
    logic [KmapAw-1:0] kmv_cnt_reg, kmv_cnt_next;

    fga_ram #(.Width(6), .Depth(KmapDepth)) u_kmap (
        .aclk, .we(km_we), .waddr(km_wa), .wdata(km_wd), .raddr(km_ra), .rdata(km_rd));
    fga_ram #(.Width(12), .Depth(CkDepth)) u_ck (
        .aclk, .we(ck_we), .waddr(ck_wa), .wdata(ck_wd), .raddr(ck_ra), .rdata(ck_rd));
    fga_ram #(.Width(32), .Depth(DictDepth)) u_dict (
        .aclk, .we(dc_we), .waddr(dc_wa), .wdata(dc_wd), .raddr(dc_ra), .rdata(dc_rd));
    fga_ram #(.Width(64), .Depth(AggGroups)) u_sums (
        .aclk, .we(sm_we), .waddr(sm_wa), .wdata(sm_wd), .raddr(sm_ra), .rdata(sm_rd));

    logic [11:0] kc_cur;
    logic [31:0] prod;
    logic        key_ok;

    assign m_tvalid = (st_reg == B_OUT);
    assign m_tdata  = {1'b0, osum_reg, ogi_reg, ost_reg};
    assign q_ready  = (st_reg == B_IDLE);
    assign prod     = va_reg * dc_rd;

    always_comb begin
        unique case (dim_reg)
            2'd0:    kc_cur = c_reg.kc0;
            2'd1:    kc_cur = c_reg.kc1;
            default: kc_cur = c_reg.kc2;
        endcase
    end
    assign key_ok = km_rd[5];

    always_comb begin
        st_next = st_reg; c_next = c_reg; clr_next = clr_reg; dim_next = dim_reg;
        g0_next = g0_reg; g1_next = g1_reg; g2_next = g2_reg; miss_next = miss_reg;
        key_next = key_reg; amt_next = amt_reg; va_next = va_reg;
        ost_next = ost_reg; ogi_next = ogi_reg; osum_next = osum_reg;
        kmv_cnt_next = kmv_cnt_reg;
        km_we = 1'b0; km_wa = '0; km_wd = '0; km_ra = '0;
        ck_we = 1'b0; ck_wa = c_reg.idx[CkAw-1:0]; ck_wd = c_reg.data[11:0];
        ck_ra = {g0_reg, g1_reg, g2_reg};
        dc_we = 1'b0; dc_wa = {c_reg.sel, c_reg.idx[DcW-1:0]}; dc_wd = c_reg.data;
        dc_ra = '0;
        sm_we = 1'b0; sm_wa = '0; sm_wd = '0; sm_ra = key_reg;
        unique case (st_reg)
            B_CLEAR: begin
                // sweep both the key map and group sums after reset
                km_we = 1'b1; km_wa = kmv_cnt_reg; km_wd = '0;
                sm_we = !clr_reg[AggAw]; sm_wa = clr_reg[AggAw-1:0]; sm_wd = '0;
                if (!clr_reg[AggAw]) clr_next = clr_reg + 1'b1;
                kmv_cnt_next = kmv_cnt_reg + 1'b1;
                if (kmv_cnt_reg == KmapAw'(KmapDepth - 1)) st_next = B_IDLE;
            end
            B_IDLE: begin
                if (q_valid) begin
                    c_next = q_cmd; ogi_next = '0; osum_next = '0;
                    ost_next = ST_LOADED;
                    dim_next = '0; miss_next = 1'b0;
                    g0_next = '0; g1_next = '0; g2_next = '0;
                    priority case (q_cmd.op)
                        OP_ROW: begin
                            if (!q_cmd.pass) begin
                                ost_next = ST_FILTERED; st_next = B_OUT;
                            end else if (q_cmd.mode == MODE_PROD) begin
                                key_next = '0; st_next = B_SUM;
                            end else begin
                                st_next = B_K0;
                            end
                        end
                        OP_LD_KMAP: st_next = B_K0;
                        OP_LD_CK:   st_next = B_CK;
                        OP_LD_DICT: st_next = B_CK;
                        OP_READ: begin
                            ost_next = ST_READ; ogi_next = q_cmd.idx[11:0];
                            key_next = q_cmd.idx[AggAw-1:0];
                            st_next = (q_cmd.idx < 15'(AggGroups)) ? B_SUM : B_OUT;
                        end
                        default: st_next = B_OUT;
                    endcase
                end
            end
            B_K0: begin
                if (c_reg.op == OP_LD_KMAP) begin
                    km_we = (c_reg.idx < 15'(KeyCodes));
                    km_wa = {c_reg.sel, c_reg.idx[KcW-1:0]};
                    km_wd = c_reg.data[5:0];
                    st_next = B_OUT;
                end else begin
                    km_ra = {dim_reg, kc_cur[KcW-1:0]};
                    st_next = B_K1;
                end
            end
            B_K1: begin
                // km_rd holds the entry of dim_reg
                if (dim_reg < c_reg.dims) begin
                    if (!key_ok) miss_next = 1'b1;
                    unique case (dim_reg)
                        2'd0:    g0_next = km_rd[GrpW-1:0];
                        2'd1:    g1_next = km_rd[GrpW-1:0];
                        default: g2_next = km_rd[GrpW-1:0];
                    endcase
                end
                if (dim_reg == 2'd2) begin
                    st_next = B_K2;
                end else begin
                    dim_next = dim_reg + 1'b1; st_next = B_K0;
                end
            end
            B_K2: begin
                if (miss_reg) begin
                    ost_next = ST_MISSING; st_next = B_OUT;
                end else begin
                    st_next = B_KW;
                end
            end
            B_KW: begin
                // composite table read issued with ck_ra
                dc_ra = {2'd0, c_reg.va[DcW-1:0]};
                st_next = B_CK;
            end
            B_CK: begin
                if (c_reg.op == OP_LD_CK) begin
                    // every 15-bit index lies inside the composite table
                    ck_we = 1'b1; st_next = B_OUT;
                end else if (c_reg.op == OP_LD_DICT) begin
                    dc_we = (c_reg.idx < 15'(DictCodes)); st_next = B_OUT;
                end else begin
                    key_next = ck_rd[AggAw-1:0];
                    va_next = dc_rd;
                    dc_ra = {2'd1, c_reg.vb[DcW-1:0]};
                    st_next = B_CKW;
                end
            end
            B_CKW: begin
                if (c_reg.mode == MODE_COST) amt_next = va_reg - dc_rd;
                else amt_next = va_reg;
                ost_next = ST_ADDED; ogi_next = 12'(key_reg);
                st_next = B_SUM;
            end
            B_SUM: begin
                // mode 2, grouped rows and read enter; dict fetch for mode 2
                dc_ra = {2'd2, c_reg.va[DcW-1:0]};
                st_next = B_SUMW;
            end
            B_SUMW: begin
                if (c_reg.op == OP_ROW && c_reg.mode == MODE_PROD) begin
                    // a 10-bit code always lies inside its bank
                    va_next = dc_rd;
                    dc_ra = {2'd3, c_reg.vb[DcW-1:0]};
                end
                st_next = B_ACC;
            end
            B_ACC: begin
                sm_wa = key_reg; sm_we = 1'b1;
                if (c_reg.op == OP_READ) begin
                    osum_next = sm_rd; sm_wd = '0;
                end else if (c_reg.mode == MODE_PROD) begin
                    sm_wd = sm_rd + 64'(prod);
                    ost_next = ST_ADDED;
                end else begin
                    sm_wd = sm_rd + 64'(amt_reg);
                end
                st_next = B_OUT;
            end
            B_OUT: begin
                if (m_tready) st_next = B_IDLE;
            end
            default: st_next = B_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= B_CLEAR; clr_reg <= '0; kmv_cnt_reg <= '0;
        end else begin
            st_reg <= st_next; clr_reg <= clr_next; kmv_cnt_reg <= kmv_cnt_next;
        end
        c_reg <= c_next; dim_reg <= dim_next; g0_reg <= g0_next; g1_reg <= g1_next;
        g2_reg <= g2_next; miss_reg <= miss_next; key_reg <= key_next;
        amt_reg <= amt_next; va_reg <= va_next; ost_reg <= ost_next;
        ogi_reg <= ogi_next; osum_reg <= osum_next;
    end
endmodule

>>> src/filtered_group_by_aggregator.sv
// top level of the filtered group-by aggregator
// depends on fga_pkg, fga_front, fga_back
`timescale 1ns / 1ps
// usage:
// s_ channel takes one item per transfer: op, filter bits, three key codes,
// two value codes, table select, index and data, packed into s_tdata.
// m_ channel returns exactly one result per item: status, group index, sum.
// cfg channel writes agg_mode (0), filter_mask (1), key_dims_used (2); the user
// writes them only while idle, and the block itself does not enforce this.
// for grouped rows, the time to m_tvalid is set by the serial key map lookups,
// one dimension at a time, and by the read-modify-write of the sum memory.
// the back end takes one item at a time and returns to idle in the cycle after
// the result transfer.
// a two-entry queue lets the front accept items while the back works.
// reset: the key map and group sums are swept to zero; no item is processed
// during the sweep, configuration writes are accepted.
// receiver stall: the result holds on m_tdata; the queue fills, then s_tready drops.
module filtered_group_by_aggregator (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // op, filter_bits, key_code_first, key_code_second, key_code_third,
    // value_code_a, value_code_b, table_select, table_index, table_data
    input  logic [111:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status, group_index, group_sum, one zero pad bit
    output logic [79:0]  m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data
);
    import fga_pkg::*;

    logic  q_valid, q_ready;
    cmd_t  q_cmd;

    // front: classify and queue
    fga_front u_front (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata,
        .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
        .q_valid, .q_ready, .q_cmd);

    // back: lookups and accumulation
    fga_back u_back (
        .aclk, .aresetn, .q_valid, .q_ready, .q_cmd,
        .m_tvalid, .m_tready, .m_tdata);
endmodule

>>> src/fga_checker.sv
// port-level checker for the aggregator, bound to the top level
// depends on fga_pkg and filtered_group_by_aggregator_macros.svh
`timescale 1ns / 1ps
`include "filtered_group_by_aggregator_macros.svh"
module fga_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [79:0]  m_tdata
);
    import fga_pkg::*;

    `FGA_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `FGA_ASSERT_NOW(a_status_range, aclk, aresetn, m_tvalid, m_tdata[2:0] <= ST_READ)
    `FGA_ASSERT_NOW(a_sum_only_read, aclk, aresetn, m_tvalid && m_tdata[2:0] != ST_READ, m_tdata[78:15] == 64'd0)
    `FGA_ASSERT_NOW(a_pad_zero, aclk, aresetn, m_tvalid, m_tdata[79] == 1'b0)
endmodule

bind filtered_group_by_aggregator fga_checker u_checker (
    .aclk, .aresetn, .m_tvalid, .m_tready, .m_tdata);
